/* hw/rtl/lzwc_pkg.sv */
package lzwc_pkg;

    localparam int CODE_W     = 12;
    localparam int DICT_DEPTH = 4096;
    localparam int BUF_DEPTH  = 5;
    localparam int BUF_IDX_W  = 3;
    localparam int SLOT_W     = CODE_W + 1;
    localparam int DICT_W     = CODE_W + 8;

    localparam logic [CODE_W-1:0] PROBE_STEP = 12'd101;
    localparam logic [CODE_W-1:0] FIRST_FREE = 12'h100;
    localparam logic [CODE_W-1:0] CLEAR_CODE = 12'hfff;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_READ_SLOT,
        ST_CHK_SLOT,
        ST_CHK_DICT,
        ST_CLR_PUT,
        ST_FINAL_CHK,
        ST_FLUSH,
        ST_DRAIN
    } lzwc_state_t;

endpackage

/* hw/rtl/lzwc_ram.sv */
module lzwc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4096
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [0:DEPTH-1];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule

/* hw/rtl/lzw_12bit_byte_compressor_unit.sv */
// lzw compressor, 12-bit codes, hashed dictionary in two single-port rams
// input channel s_*: one raw file byte per beat, s_tlast marks the last byte
// output channel m_*: packed big-endian code stream, one byte per beat;
//   m_tuser is high on the last byte caused by an input beat, m_tlast on
//   the final byte of the compressed file
// a byte whose string is found is looked up slot by slot (slot ram read,
// then dictionary ram read and compare); a miss probes occupied slots the
// same way, then sends the prefix; the clear code and, on a last byte, a
// flush take a state each; a file's first byte needs no lookup; then the
// output register drains the beat's bytes (0 to 5); after reset, after the
// dictionary fills (code 4095 sent) and after every last byte, a pass over
// all 4096 slots clears the slot ram; s_tready stays low then; when the
// receiver stalls, the output register holds its beat and the block stops
// inside the drain phase; once no clear is due, the next input beat is taken
// when all bytes of the current one sit in or have left the output register
module lzw_12bit_byte_compressor_unit (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // data_byte
    input  logic       s_tlast,   // final_byte
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // out_byte
    output logic       m_tuser,   // run_end
    output logic       m_tlast    // stream_end
);
    import lzwc_pkg::*;

    lzwc_state_t state_reg, state_next;

    logic [CODE_W-1:0]    prefix_reg, prefix_next;
    logic [CODE_W-1:0]    nfc_reg, nfc_next;
    logic [CODE_W-1:0]    slot_reg, slot_next;
    logic [CODE_W-1:0]    clr_reg, clr_next;
    logic [7:0]           byte_reg;
    logic                 last_reg;
    logic                 started_reg, started_next;
    logic [3:0]           held_reg, held_next;
    logic                 np_reg, np_next;
    logic                 need_clr_reg, need_clr_next;
    logic [7:0]           buf_reg [0:BUF_DEPTH-1];
    logic [BUF_IDX_W-1:0] cnt_reg, cnt_next;
    logic [BUF_IDX_W-1:0] rd_reg, rd_next;
    logic                 ovalid_reg, ovalid_next;
    logic [7:0]           odata_reg;
    logic                 ouser_reg, olast_reg;

    logic                 accept;
    logic                 put_en;
    logic [CODE_W-1:0]    put_code;
    logic                 flush_en;
    logic                 out_load;

    logic                 slot_we;
    logic [CODE_W-1:0]    slot_addr;
    logic [SLOT_W-1:0]    slot_wdata, slot_rdata;
    logic                 dict_we;
    logic [CODE_W-1:0]    dict_addr;
    logic [DICT_W-1:0]    dict_wdata, dict_rdata;

    lzwc_ram #(.WIDTH(SLOT_W), .DEPTH(DICT_DEPTH)) u_slot_ram (
        .clk   (clk),
        .we    (slot_we),
        .addr  (slot_addr),
        .wdata (slot_wdata),
        .rdata (slot_rdata)
    );

    lzwc_ram #(.WIDTH(DICT_W), .DEPTH(DICT_DEPTH)) u_dict_ram (
        .clk   (clk),
        .we    (dict_we),
        .addr  (dict_addr),
        .wdata (dict_wdata),
        .rdata (dict_rdata)
    );

    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign m_tvalid = ovalid_reg;
    assign m_tdata  = odata_reg;
    assign m_tuser  = ouser_reg;
    assign m_tlast  = olast_reg;

    assign out_load = (state_reg == ST_DRAIN) && (rd_reg != cnt_reg)
                      && (!ovalid_reg || m_tready);

    always_comb
    begin
        state_next    = state_reg;
        prefix_next   = prefix_reg;
        nfc_next      = nfc_reg;
        slot_next     = slot_reg;
        clr_next      = clr_reg;
        started_next  = started_reg;
        need_clr_next = need_clr_reg;
        rd_next       = rd_reg;
        put_en        = 1'b0;
        put_code      = prefix_reg;
        flush_en      = 1'b0;
        slot_we       = 1'b0;
        slot_addr     = slot_reg;
        slot_wdata    = {1'b1, nfc_reg};
        dict_we       = 1'b0;
        dict_addr     = slot_rdata[CODE_W-1:0];
        dict_wdata    = {prefix_reg, byte_reg};
        ovalid_next   = ovalid_reg;
        if (ovalid_reg && m_tready)
        begin
            ovalid_next = 1'b0;
        end
        if (out_load)
        begin
            ovalid_next = 1'b1;
            rd_next     = rd_reg + 1'b1;
        end

        case (state_reg)
            ST_CLEAR:
            begin
                slot_we    = 1'b1;
                slot_addr  = clr_reg;
                slot_wdata = '0;
                clr_next   = clr_reg + 1'b1;
                if (clr_reg == CLEAR_CODE)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (!started_reg)
                    begin
                        prefix_next  = {4'd0, s_tdata};
                        started_next = 1'b1;
                        state_next   = ST_FINAL_CHK;
                    end
                    else
                    begin
                        slot_next  = prefix_reg ^ {1'b0, s_tdata, 3'd0};
                        state_next = ST_READ_SLOT;
                    end
                end
            end
            ST_READ_SLOT:
            begin
                state_next = ST_CHK_SLOT;
            end
            ST_CHK_SLOT:
            begin
                if (slot_rdata[CODE_W])
                begin
                    state_next = ST_CHK_DICT;
                end
                else
                begin
                    // miss: send prefix, add the new string if room remains
                    put_en = 1'b1;
                    if (nfc_reg != CLEAR_CODE)
                    begin
                        slot_we   = 1'b1;
                        dict_we   = 1'b1;
                        dict_addr = nfc_reg;
                        nfc_next  = nfc_reg + 1'b1;
                    end
                    prefix_next = {4'd0, byte_reg};
                    if (nfc_next == CLEAR_CODE)
                    begin
                        state_next = ST_CLR_PUT;
                    end
                    else
                    begin
                        state_next = ST_FINAL_CHK;
                    end
                end
            end
            ST_CHK_DICT:
            begin
                if (dict_rdata == {prefix_reg, byte_reg})
                begin
                    prefix_next = slot_rdata[CODE_W-1:0];
                    state_next  = ST_FINAL_CHK;
                end
                else
                begin
                    slot_next  = slot_reg + PROBE_STEP;
                    state_next = ST_READ_SLOT;
                end
            end
            ST_CLR_PUT:
            begin
                put_en        = 1'b1;
                put_code      = CLEAR_CODE;
                nfc_next      = FIRST_FREE;
                need_clr_next = 1'b1;
                state_next    = ST_FINAL_CHK;
            end
            ST_FINAL_CHK:
            begin
                if (last_reg)
                begin
                    put_en     = 1'b1;
                    state_next = ST_FLUSH;
                end
                else
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_FLUSH:
            begin
                flush_en      = 1'b1;
                prefix_next   = '0;
                started_next  = 1'b0;
                nfc_next      = FIRST_FREE;
                need_clr_next = 1'b1;
                state_next    = ST_DRAIN;
            end
            ST_DRAIN:
            begin
                if (rd_reg == cnt_reg)
                begin
                    if (need_clr_reg)
                    begin
                        need_clr_next = 1'b0;
                        clr_next      = '0;
                        state_next    = ST_CLEAR;
                    end
                    else
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase

        // code packing into the byte buffer
        held_next = held_reg;
        np_next   = np_reg;
        cnt_next  = cnt_reg;
        if (accept)
        begin
            cnt_next = '0;
            rd_next  = '0;
        end
        if (put_en)
        begin
            if (!np_reg)
            begin
                held_next = put_code[3:0];
                np_next   = 1'b1;
                cnt_next  = cnt_reg + 1'b1;
            end
            else
            begin
                held_next = '0;
                np_next   = 1'b0;
                cnt_next  = cnt_reg + 2'd2;
            end
        end
        if (flush_en)
        begin
            held_next = '0;
            np_next   = 1'b0;
            if (np_reg)
            begin
                cnt_next = cnt_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_CLEAR;
            prefix_reg   <= '0;
            nfc_reg      <= FIRST_FREE;
            clr_reg      <= '0;
            started_reg  <= 1'b0;
            held_reg     <= '0;
            np_reg       <= 1'b0;
            need_clr_reg <= 1'b0;
            cnt_reg      <= '0;
            rd_reg       <= '0;
            ovalid_reg   <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            prefix_reg   <= prefix_next;
            nfc_reg      <= nfc_next;
            clr_reg      <= clr_next;
            started_reg  <= started_next;
            held_reg     <= held_next;
            np_reg       <= np_next;
            need_clr_reg <= need_clr_next;
            cnt_reg      <= cnt_next;
            rd_reg       <= rd_next;
            ovalid_reg   <= ovalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        slot_reg <= slot_next;
        if (accept)
        begin
            byte_reg <= s_tdata;
            last_reg <= s_tlast;
        end
        if (put_en)
        begin
            if (!np_reg)
            begin
                buf_reg[cnt_reg] <= put_code[11:4];
            end
            else
            begin
                buf_reg[cnt_reg]        <= {held_reg, put_code[11:8]};
                buf_reg[cnt_reg + 1'b1] <= put_code[7:0];
            end
        end
        if (flush_en && np_reg)
        begin
            buf_reg[cnt_reg] <= {held_reg, 4'd0};
        end
        if (out_load)
        begin
            odata_reg <= buf_reg[rd_reg];
            ouser_reg <= (rd_reg + 1'b1 == cnt_reg);
            olast_reg <= (rd_reg + 1'b1 == cnt_reg) && last_reg;
        end
    end

    a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= 3'd5 && rd_reg <= cnt_reg)
        else $error("byte buffer count out of range");

    a_nfc_floor: assert property (@(posedge clk) disable iff (!rst_n)
        nfc_reg >= FIRST_FREE)
        else $error("next free code below first free code");

    a_dict_room: assert property (@(posedge clk) disable iff (!rst_n)
        dict_we |-> nfc_reg != CLEAR_CODE)
        else $error("dictionary written while full");

    a_accept_drained: assert property (@(posedge clk) disable iff (!rst_n)
        accept |-> rd_reg == cnt_reg && !need_clr_reg)
        else $error("input taken before previous bytes were queued");

    a_clear_put: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_CLR_PUT |-> $past(state_reg) == ST_CHK_SLOT)
        else $error("clear code sent outside a miss");

endmodule
